[sv/binary_max_heap_queue_macros.svh]
// assertion helpers used by the checker file
`ifndef BINARY_MAX_HEAP_QUEUE_MACROS_SVH
`define BINARY_MAX_HEAP_QUEUE_MACROS_SVH

// same-cycle implication, quiet during reset
`define BMHQ_ASSERT_IMP(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("bmhq check failed");

// next-cycle implication, quiet during reset
`define BMHQ_ASSERT_NXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("bmhq check failed");

`endif

[sv/bmhq_pkg.sv]
package bmhq_pkg;

	// fixed widths of the channel fields
	localparam int IO_KEY_BITS  = 32;
	localparam int CNT_OUT_BITS = 7;

	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_POP    = 1'b1
	} mode_t;

	// request from the front end to the heap engine
	typedef struct packed {
		logic  start;
		mode_t mode;
	} cmd_t;

	// engine status back to the front end
	typedef struct packed {
		logic idle;
		logic done;
		logic dropped;
	} stat_t;

endpackage

[sv/bmhq_op_if.sv]
interface bmhq_op_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   mode;
	logic signed [bmhq_pkg::IO_KEY_BITS-1:0] key_in;

	modport source (output valid, mode, key_in, input ready);
	modport sink   (input valid, mode, key_in, output ready);
endinterface

[sv/bmhq_res_if.sv]
interface bmhq_res_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [bmhq_pkg::IO_KEY_BITS-1:0]  top_key;
	logic                                    is_empty;
	logic        [bmhq_pkg::CNT_OUT_BITS-1:0] entry_count;
	logic                                    dropped;

	modport source (output valid, top_key, is_empty, entry_count, dropped, input ready);
	modport sink   (input valid, top_key, is_empty, entry_count, dropped, output ready);
endinterface

[sv/bmhq_cmp.sv]
// shared signed greater-than compare
module bmhq_cmp #(
	parameter int KEY_BITS = 32
) (
	input  logic [KEY_BITS-1:0] a,
	input  logic [KEY_BITS-1:0] b,
	output logic                gt
);

	assign gt = $signed(a) > $signed(b);

endmodule

[sv/bmhq_eng.sv]
// heap sequencer: key store, sift-up and sift-down over one comparator
module bmhq_eng #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 32,
	localparam int AW = $clog2(CAPACITY),
	localparam int PW = $clog2(CAPACITY + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bmhq_pkg::cmd_t       cmd,
	input  logic [KEY_BITS-1:0]  key,
	input  logic                 rsp_ready,
	output bmhq_pkg::stat_t      stat,
	output logic [KEY_BITS-1:0]  root,
	output logic [PW-1:0]        count
);

	localparam int CW = PW + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP,
		ST_UPC,
		ST_LOAD,
		ST_DN,
		ST_DNL,
		ST_DNR,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [PW-1:0]       n_q;
	logic [PW-1:0]       pos_q;
	logic [PW-1:0]       sel_q;
	logic [KEY_BITS-1:0] x_q;
	logic [KEY_BITS-1:0] best_q;
	logic [KEY_BITS-1:0] root_q;
	logic                dropped_q;

	logic [KEY_BITS-1:0] mem_q [CAPACITY];
	logic [KEY_BITS-1:0] rda_q;
	logic [KEY_BITS-1:0] rdb_q;

	logic                mem_we;
	logic [AW-1:0]       mem_wa;
	logic [KEY_BITS-1:0] mem_wd;
	logic                mem_re;
	logic [AW-1:0]       ra_a;
	logic [AW-1:0]       ra_b;

	logic [KEY_BITS-1:0] cmp_a;
	logic [KEY_BITS-1:0] cmp_b;
	logic                gt;

	logic [CW-1:0]       lpos;
	logic [CW-1:0]       rpos;
	logic                l_ok;
	logic                r_ok;
	logic [PW-1:0]       parent;
	logic                take_r;
	logic [PW-1:0]       new_sel;
	logic [KEY_BITS-1:0] new_val;

	function automatic logic [AW-1:0] pos_idx(input logic [PW-1:0] p);
		logic [PW-1:0] d;
		d = p - PW'(1);
		return d[AW-1:0];
	endfunction

	bmhq_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.gt (gt)
	);

	// child and parent positions of the current slot
	assign lpos   = {pos_q, 1'b0};
	assign rpos   = lpos + CW'(1);
	assign l_ok   = lpos <= {1'b0, n_q};
	assign r_ok   = rpos <= {1'b0, n_q};
	assign parent = pos_q >> 1;

	assign take_r  = r_ok && gt;
	assign new_sel = take_r ? rpos[PW-1:0] : sel_q;
	assign new_val = take_r ? rdb_q : best_q;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = pos_idx(pos_q);
		mem_wd = x_q;
		mem_re = 1'b0;
		ra_a   = pos_idx(n_q);
		ra_b   = pos_idx(n_q);
		cmp_a  = x_q;
		cmp_b  = rda_q;
		unique case (state_q)
			ST_IDLE: begin
				// last entry is fetched as the pop is accepted
				mem_re = cmd.start && (cmd.mode == bmhq_pkg::MODE_POP);
			end
			ST_UP: begin
				if (pos_q == PW'(1)) begin
					mem_we = 1'b1;
				end else begin
					mem_re = 1'b1;
					ra_a   = pos_idx(parent);
				end
			end
			ST_UPC: begin
				mem_we = 1'b1;
				if (gt) begin
					mem_wd = rda_q;
				end
			end
			ST_DN: begin
				if (!l_ok) begin
					mem_we = 1'b1;
				end else begin
					mem_re = 1'b1;
					ra_a   = AW'(lpos - CW'(1));
					ra_b   = AW'(rpos - CW'(1));
				end
			end
			ST_DNL: begin
				cmp_a = rda_q;
				cmp_b = x_q;
			end
			ST_DNR: begin
				cmp_a  = rdb_q;
				cmp_b  = best_q;
				mem_we = 1'b1;
				if (new_sel != '0) begin
					mem_wd = new_val;
				end
			end
			default: begin
			end
		endcase
	end

	// key store, registered reads
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rda_q <= mem_q[ra_a];
			rdb_q <= mem_q[ra_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			n_q       <= '0;
			pos_q     <= '0;
			sel_q     <= '0;
			x_q       <= '0;
			best_q    <= '0;
			root_q    <= '0;
			dropped_q <= 1'b0;
		end else begin
			// every write lands at the current slot, so slot one mirrors the root
			if (mem_we && pos_q == PW'(1)) begin
				root_q <= mem_wd;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						dropped_q <= 1'b0;
						if (cmd.mode == bmhq_pkg::MODE_INSERT) begin
							if (n_q == PW'(CAPACITY)) begin
								dropped_q <= 1'b1;
								state_q   <= ST_DONE;
							end else begin
								n_q     <= n_q + PW'(1);
								pos_q   <= n_q + PW'(1);
								x_q     <= key;
								state_q <= ST_UP;
							end
						end else if (n_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_UP: begin
					state_q <= (pos_q == PW'(1)) ? ST_DONE : ST_UPC;
				end
				ST_UPC: begin
					if (gt) begin
						pos_q   <= parent;
						state_q <= ST_UP;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_LOAD: begin
					x_q     <= rda_q;
					n_q     <= n_q - PW'(1);
					pos_q   <= PW'(1);
					state_q <= (n_q == PW'(1)) ? ST_DONE : ST_DN;
				end
				ST_DN: begin
					state_q <= l_ok ? ST_DNL : ST_DONE;
				end
				ST_DNL: begin
					if (gt) begin
						best_q <= rda_q;
						sel_q  <= lpos[PW-1:0];
					end else begin
						best_q <= x_q;
						sel_q  <= '0;
					end
					state_q <= ST_DNR;
				end
				ST_DNR: begin
					if (new_sel == '0) begin
						state_q <= ST_DONE;
					end else begin
						pos_q   <= new_sel;
						state_q <= ST_DN;
					end
				end
				ST_DONE: begin
					if (rsp_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign stat.idle    = state_q == ST_IDLE;
	assign stat.done    = state_q == ST_DONE;
	assign stat.dropped = dropped_q;
	assign root         = root_q;
	assign count        = n_q;

endmodule

[sv/binary_max_heap_queue.sv]
// insert: the key takes the new last slot and rises past each smaller parent up to the root;
// remove: the last entry goes to the root and sinks toward the larger child until it lands on
// a leaf or is no smaller than both children; a full insert, an empty remove or the last entry skip the sift
// items: one at a time, the next beat can be taken in the cycle the result shows, a pace
// set by the key store's registered read and the single comparator that every level uses
// reset: arst_n clears the entry count and all control; the key store is not cleared
module binary_max_heap_queue #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	bmhq_op_if.sink           op,
	bmhq_res_if.source        res
);

	localparam int PW  = $clog2(CAPACITY + 1);
	localparam int IOK = bmhq_pkg::IO_KEY_BITS;
	localparam int CO  = bmhq_pkg::CNT_OUT_BITS;

	bmhq_pkg::cmd_t      cmd;
	bmhq_pkg::stat_t     stat;
	logic [KEY_BITS-1:0] key_fit;
	logic [KEY_BITS-1:0] root;
	logic [PW-1:0]       count;
	logic                rsp_ready;

	// result register: one beat parked here while the engine may go on
	logic                res_valid_q;
	logic [IOK-1:0]      top_key_q;
	logic                is_empty_q;
	logic [CO-1:0]       entry_count_q;
	logic                dropped_q;

	// input key sign-extended or narrowed to the stored key width
	assign key_fit = KEY_BITS'(op.key_in);

	// engine takes a beat only from idle
	assign op.ready  = stat.idle;
	assign cmd.start = op.valid && op.ready;
	assign cmd.mode  = bmhq_pkg::mode_t'(op.mode);

	// finished item hands over once the result register is free or draining
	assign rsp_ready = !res_valid_q || res.ready;

	bmhq_eng #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_eng (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.key       (key_fit),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.root      (root),
		.count     (count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (stat.done && rsp_ready) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// payload side, no reset needed
	always_ff @(posedge clk) begin
		if (stat.done && rsp_ready) begin
			// empty heap reports all ones for the top key
			top_key_q     <= (count == '0) ? '1 : IOK'($signed(root));
			is_empty_q    <= count == '0;
			entry_count_q <= CO'(count);
			dropped_q     <= stat.dropped;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.top_key     = top_key_q;
	assign res.is_empty    = is_empty_q;
	assign res.entry_count = entry_count_q;
	assign res.dropped     = dropped_q;

endmodule

[sv/bmhq_chk.sv]
`include "binary_max_heap_queue_macros.svh"

module bmhq_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                op_valid,
	input logic                                op_ready,
	input logic                                res_valid,
	input logic                                res_ready,
	input logic [bmhq_pkg::IO_KEY_BITS-1:0]    top_key,
	input logic                                is_empty,
	input logic [bmhq_pkg::CNT_OUT_BITS-1:0]   entry_count,
	input logic                                dropped
);

	// result beat holds until taken
	`BMHQ_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)

	// one item in flight: no second beat right after an accepted one
	`BMHQ_ASSERT_NXT(a_busy_after_op, clk, arst_n, op_valid && op_ready, !op_ready)

	// empty heap shows no entries and the all-ones top key
	`BMHQ_ASSERT_IMP(a_empty_cnt, clk, arst_n, res_valid && is_empty, entry_count == '0)
	`BMHQ_ASSERT_IMP(a_empty_key, clk, arst_n, res_valid && is_empty, top_key == '1)

	// a refused insert comes from a full heap, so it never reports an empty heap
	`BMHQ_ASSERT_IMP(a_drop_full, clk, arst_n, res_valid && dropped, !is_empty)

endmodule

bind binary_max_heap_queue bmhq_chk u_bmhq_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.op_valid    (op.valid),
	.op_ready    (op.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.top_key     (res.top_key),
	.is_empty    (res.is_empty),
	.entry_count (res.entry_count),
	.dropped     (res.dropped)
);
